[rtl/nbg_pkg.sv]
// ============================================================================
// nbg_pkg
// Shared types, sizes and saturation helpers for the 2D gravity block.
// ============================================================================
`default_nettype none

package nbg_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = IDX_W + 1;

    localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_GRAV_CONST = 2'd1;
    localparam logic [1:0] CFG_STEP_COUNT = 2'd2;

    // input beat
    typedef struct packed {
        logic [30:0]        mass;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               last;
    } t_in;

    // result beat
    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               last_out;
    } t_out;

    // datapath commands
    typedef enum logic [4:0] {
        C_NOP, C_LOAD, C_READ, C_LATQ, C_LATK, C_LATU, C_CLR, C_WRQ, C_WRK,
        C_WRU, C_EMIT, C_SQX, C_SQY, C_SQRT, C_MGQ, C_MMK, C_DIVR, C_MFX,
        C_MFY, C_MVX, C_MVY, C_AFX, C_AFY, C_DVX, C_DVY
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] addr;
        logic             last;
    } t_ctl;

    typedef struct packed {
        logic done;
        logic r_zero;
        logic m_zero;
        logic out_full;
    } t_sts;

    // saturate a 50-bit signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic [49:0] v);
        if (v[49:31] == {19{v[49]}}) begin
            return v[31:0];
        end
        return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // saturate a 49-bit signed sum to 48 bits
    function automatic logic [47:0] sat48(input logic [48:0] v);
        if (v[48] == v[47]) begin
            return v[47:0];
        end
        return v[48] ? 48'h8000_0000_0000 : LIM48;
    endfunction

    // clamp an unsigned 64-bit magnitude at LIM48
    function automatic logic [47:0] satq(input logic [63:0] v);
        if (v[63:47] == '0) begin
            return {1'b0, v[46:0]};
        end
        return LIM48;
    endfunction

endpackage

`default_nettype wire

[rtl/nbg_ctrl.sv]
// ============================================================================
// nbg_ctrl
// Sequencer: load, force clearing, pair loop, Euler update and result emission.
// ============================================================================
`default_nettype none

module nbg_ctrl
    import nbg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_last,
    output logic             o_in_ready,
    input  wire logic [15:0] i_step_count,
    input  wire t_sts        i_sts,
    output t_ctl             o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_PRQ, S_PRK, S_PLK, S_SQX, S_SQY, S_SQRT, S_MGQ, S_MMK,
        S_DV1, S_DV2, S_DV3, S_MFX, S_MFY, S_WRQ, S_WRK, S_URD, S_ULAT, S_MVX,
        S_MVY, S_AFX, S_DVX, S_AFY, S_DVY, S_UWR, S_ERD, S_EOUT, S_EWAIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_a, n_a;
    logic [CNT_W-1:0] r_b, n_b;
    logic [15:0]      r_t, n_t;
    logic             r_go, n_go;

    logic [CNT_W-1:0] a_inc, a_inc2, b_inc;
    logic [15:0]      t_inc;
    logic             eng;
    t_cmd             eng_op;
    t_state           eng_nxt;
    logic             next_pair;

    assign a_inc  = r_a + CNT_W'(1);
    assign a_inc2 = r_a + CNT_W'(2);
    assign b_inc  = r_b + CNT_W'(1);
    assign t_inc  = r_t + 16'd1;

    // decode state into commands and next values
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_a        = r_a;
        n_b        = r_b;
        n_t        = r_t;
        n_go       = r_go;
        o_ctl      = '{cmd: C_NOP, addr: r_a[IDX_W-1:0], last: 1'b0};
        o_in_ready = 1'b0;
        eng        = 1'b0;
        eng_op     = C_NOP;
        eng_nxt    = r_state;
        next_pair  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_cnt < CNT_W'(MAX_PARTICLES)) begin
                        o_ctl.cmd  = C_LOAD;
                        o_ctl.addr = r_cnt[IDX_W-1:0];
                        n_cnt      = r_cnt + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_n     = (r_cnt < CNT_W'(MAX_PARTICLES)) ? r_cnt + CNT_W'(1) : r_cnt;
                        n_cnt   = '0;
                        n_a     = '0;
                        n_t     = '0;
                        n_state = (i_step_count == '0) ? S_ERD : S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_ctl.cmd = C_CLR;
                if (a_inc < r_n) begin
                    n_a = a_inc;
                end else begin
                    n_a = '0;
                    if (r_n > CNT_W'(1)) begin
                        n_b     = CNT_W'(1);
                        n_state = S_PRQ;
                    end else begin
                        n_state = S_URD;
                    end
                end
            end
            S_PRQ: begin
                o_ctl.cmd = C_READ;
                n_state   = S_PRK;
            end
            S_PRK: begin
                o_ctl.cmd  = C_LATQ;
                o_ctl.addr = r_b[IDX_W-1:0];
                n_state    = S_PLK;
            end
            S_PLK: begin
                o_ctl.cmd = C_LATK;
                n_state   = S_SQX;
            end
            S_SQX:  begin eng = 1'b1; eng_op = C_SQX;  eng_nxt = S_SQY;  end
            S_SQY:  begin eng = 1'b1; eng_op = C_SQY;  eng_nxt = S_SQRT; end
            S_SQRT: begin eng = 1'b1; eng_op = C_SQRT; eng_nxt = S_MGQ;  end
            S_MGQ: begin
                // coincident pair: skip it
                if (!r_go && i_sts.r_zero) begin
                    next_pair = 1'b1;
                end else begin
                    eng = 1'b1; eng_op = C_MGQ; eng_nxt = S_MMK;
                end
            end
            S_MMK:  begin eng = 1'b1; eng_op = C_MMK;  eng_nxt = S_DV1;  end
            S_DV1:  begin eng = 1'b1; eng_op = C_DIVR; eng_nxt = S_DV2;  end
            S_DV2:  begin eng = 1'b1; eng_op = C_DIVR; eng_nxt = S_DV3;  end
            S_DV3:  begin eng = 1'b1; eng_op = C_DIVR; eng_nxt = S_MFX;  end
            S_MFX:  begin eng = 1'b1; eng_op = C_MFX;  eng_nxt = S_MFY;  end
            S_MFY:  begin eng = 1'b1; eng_op = C_MFY;  eng_nxt = S_WRQ;  end
            S_WRQ: begin
                o_ctl.cmd = C_WRQ;
                n_state   = S_WRK;
            end
            S_WRK: begin
                o_ctl.cmd  = C_WRK;
                o_ctl.addr = r_b[IDX_W-1:0];
                next_pair  = 1'b1;
            end
            S_URD: begin
                o_ctl.cmd = C_READ;
                n_state   = S_ULAT;
            end
            S_ULAT: begin
                o_ctl.cmd = C_LATU;
                n_state   = S_MVX;
            end
            S_MVX: begin eng = 1'b1; eng_op = C_MVX; eng_nxt = S_MVY; end
            S_MVY: begin
                eng = 1'b1; eng_op = C_MVY;
                eng_nxt = i_sts.m_zero ? S_UWR : S_AFX;
            end
            S_AFX: begin eng = 1'b1; eng_op = C_AFX; eng_nxt = S_DVX; end
            S_DVX: begin eng = 1'b1; eng_op = C_DVX; eng_nxt = S_AFY; end
            S_AFY: begin eng = 1'b1; eng_op = C_AFY; eng_nxt = S_DVY; end
            S_DVY: begin eng = 1'b1; eng_op = C_DVY; eng_nxt = S_UWR; end
            S_UWR: begin
                o_ctl.cmd = C_WRU;
                if (a_inc < r_n) begin
                    n_a     = a_inc;
                    n_state = S_URD;
                end else begin
                    n_a     = '0;
                    n_t     = t_inc;
                    n_state = (t_inc < i_step_count) ? S_CLR : S_ERD;
                end
            end
            S_ERD: begin
                o_ctl.cmd = C_READ;
                n_state   = S_EOUT;
            end
            S_EOUT: begin
                o_ctl.cmd  = C_EMIT;
                o_ctl.last = (a_inc == r_n);
                n_state    = S_EWAIT;
            end
            S_EWAIT: begin
                if (!i_sts.out_full) begin
                    if (a_inc < r_n) begin
                        n_a     = a_inc;
                        n_state = S_ERD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // start the arithmetic unit once, then wait for its finish
        if (eng) begin
            if (!r_go) begin
                o_ctl.cmd = eng_op;
                n_go      = 1'b1;
            end else if (i_sts.done) begin
                n_go    = 1'b0;
                n_state = eng_nxt;
            end
        end

        // advance to the next pair, or on to the update pass
        if (next_pair) begin
            if (b_inc < r_n) begin
                n_b     = b_inc;
                n_state = S_PRQ;
            end else if (a_inc2 < r_n) begin
                n_a     = a_inc;
                n_b     = a_inc2;
                n_state = S_PRQ;
            end else begin
                n_a     = '0;
                n_state = S_URD;
            end
        end
    end

    // hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_t     <= '0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_a     <= n_a;
            r_b     <= n_b;
            r_t     <= n_t;
            r_go    <= n_go;
        end
    end

endmodule

`default_nettype wire

[rtl/nbg_dp.sv]
// ============================================================================
// nbg_dp
// Particle memories, working registers, shared iterative multiply / divide /
// square-root unit and the result register.
// ============================================================================
`default_nettype none

module nbg_dp
    import nbg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl        i_ctl,
    input  wire t_in         i_in_data,
    input  wire logic [30:0] i_time_step,
    input  wire logic [30:0] i_grav_const,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data
);

    typedef enum logic [1:0] {E_MUL, E_DIV, E_SQRT} t_emode;

    // particle memories
    logic [30:0]        mem_m  [MAX_PARTICLES];
    logic signed [31:0] mem_px [MAX_PARTICLES];
    logic signed [31:0] mem_py [MAX_PARTICLES];
    logic signed [31:0] mem_vx [MAX_PARTICLES];
    logic signed [31:0] mem_vy [MAX_PARTICLES];
    logic signed [47:0] mem_fx [MAX_PARTICLES];
    logic signed [47:0] mem_fy [MAX_PARTICLES];

    logic [30:0]        r_rd_m;
    logic signed [31:0] r_rd_px, r_rd_py, r_rd_vx, r_rd_vy;
    logic signed [47:0] r_rd_fx, r_rd_fy;

    // working registers
    logic [30:0]        r_q_m, r_k_m;
    logic signed [31:0] r_q_px, r_q_py, r_q_vx, r_q_vy;
    logic signed [47:0] r_q_fx, r_q_fy, r_k_fx, r_k_fy;
    logic [31:0]        r_ax, r_ay;
    logic               r_sgx, r_sgy, r_s;
    logic [62:0]        r_sq;
    logic [32:0]        r_r;
    logic [47:0]        r_c;
    logic [46:0]        r_fx, r_fy;

    // iterative unit
    logic        r_busy, r_fin;
    t_emode      r_mode;
    t_cmd        r_eop;
    logic [5:0]  r_cnt;
    logic [47:0] r_ea;
    logic [31:0] r_eb;
    logic [79:0] r_p;
    logic [34:0] r_rem;

    logic        r_ovalid;
    t_out        r_out;

    // ------------------------------------------------------------------
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [47:0] abs48(input logic [47:0] v);
        return v[47] ? (~v + 48'd1) : v;
    endfunction

    // pair separation from the latched q and the k being read
    logic [32:0] dx, dy, adx, ady;
    logic [30:0] bx, by;
    assign dx  = {r_q_px[31], r_q_px} - {r_rd_px[31], r_rd_px};
    assign dy  = {r_q_py[31], r_q_py} - {r_rd_py[31], r_rd_py};
    assign adx = dx[32] ? (~dx + 33'd1) : dx;
    assign ady = dy[32] ? (~dy + 33'd1) : dy;
    assign bx  = r_s ? r_ax[31:1] : r_ax[30:0];
    assign by  = r_s ? r_ay[31:1] : r_ay[30:0];

    // operand selection for the iterative unit
    logic        e_start;
    t_emode      e_mode;
    logic [47:0] e_a;
    logic [31:0] e_b;
    logic [63:0] e_num;

    always_comb begin
        e_start = 1'b1;
        e_mode  = E_MUL;
        e_a     = '0;
        e_b     = '0;
        e_num   = '0;
        case (i_ctl.cmd)
            C_SQX: begin e_a = {17'b0, bx}; e_b = {1'b0, bx}; end
            C_SQY: begin e_a = {17'b0, by}; e_b = {1'b0, by}; end
            C_SQRT: begin
                e_mode = E_SQRT;
                e_num  = {1'b0, r_sq};
            end
            C_MGQ: begin e_a = {17'b0, i_grav_const}; e_b = {1'b0, r_q_m}; end
            C_MMK: begin e_a = r_c; e_b = {1'b0, r_k_m}; end
            C_DIVR: begin
                e_mode = E_DIV;
                e_a    = {15'b0, r_r};
                e_num  = {r_c, 16'b0};
            end
            C_MFX: begin e_a = r_c; e_b = r_ax; end
            C_MFY: begin e_a = r_c; e_b = r_ay; end
            C_MVX: begin e_a = {16'b0, abs32(r_q_vx)}; e_b = {1'b0, i_time_step}; end
            C_MVY: begin e_a = {16'b0, abs32(r_q_vy)}; e_b = {1'b0, i_time_step}; end
            C_AFX: begin e_a = abs48(r_q_fx); e_b = {1'b0, i_time_step}; end
            C_AFY: begin e_a = abs48(r_q_fy); e_b = {1'b0, i_time_step}; end
            C_DVX, C_DVY: begin
                e_mode = E_DIV;
                e_a    = {17'b0, r_q_m};
                e_num  = {r_c, 16'b0};
            end
            default: e_start = 1'b0;
        endcase
    end

    // one step of each algorithm
    logic [48:0] mul_sum;
    logic [34:0] div_t, sq_t, sq_trial;
    logic        div_ge, sq_ge;
    assign mul_sum  = {1'b0, r_p[79:32]} + (r_p[0] ? {1'b0, r_ea} : 49'd0);
    assign div_t    = {r_rem[33:0], r_p[63]};
    assign div_ge   = {13'b0, div_t} >= r_ea;
    assign sq_t     = {r_rem[32:0], r_p[63:62]};
    assign sq_trial = {1'b0, r_eb, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // control of the iterative unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (e_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    // iterate: shift-add multiply, restoring divide, digit-pair square root
    always_ff @(posedge i_clk) begin
        if (e_start) begin
            r_mode <= e_mode;
            r_eop  <= i_ctl.cmd;
            r_ea   <= e_a;
            r_eb   <= '0;
            r_rem  <= '0;
            r_cnt  <= (e_mode == E_DIV) ? 6'd63 : 6'd31;
            r_p    <= (e_mode == E_MUL) ? {48'b0, e_b} : {16'b0, e_num};
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            case (r_mode)
                E_MUL: r_p <= {mul_sum, r_p[31:1]};
                E_DIV: begin
                    r_rem       <= div_ge ? (div_t - r_ea[34:0]) : div_t;
                    r_p[63:0]   <= {r_p[62:0], div_ge};
                end
                default: begin
                    r_rem       <= sq_ge ? (sq_t - sq_trial) : sq_t;
                    r_eb        <= {r_eb[30:0], sq_ge};
                    r_p[63:0]   <= {r_p[61:0], 2'b00};
                end
            endcase
        end
    end

    // finished results
    logic [47:0] mulq_v, divq_v;
    logic [49:0] mv_x, mv_y, dv_x, dv_y;
    assign mulq_v = satq(r_p[79:16]);
    assign divq_v = satq(r_p[63:0]);
    assign mv_x = r_q_vx[31] ? ({{18{r_q_px[31]}}, r_q_px} - {3'b0, r_p[62:16]})
                             : ({{18{r_q_px[31]}}, r_q_px} + {3'b0, r_p[62:16]});
    assign mv_y = r_q_vy[31] ? ({{18{r_q_py[31]}}, r_q_py} - {3'b0, r_p[62:16]})
                             : ({{18{r_q_py[31]}}, r_q_py} + {3'b0, r_p[62:16]});
    assign dv_x = r_q_fx[47] ? ({{18{r_q_vx[31]}}, r_q_vx} - {2'b0, divq_v})
                             : ({{18{r_q_vx[31]}}, r_q_vx} + {2'b0, divq_v});
    assign dv_y = r_q_fy[47] ? ({{18{r_q_vy[31]}}, r_q_vy} - {2'b0, divq_v})
                             : ({{18{r_q_vy[31]}}, r_q_vy} + {2'b0, divq_v});

    // latch operands and take results
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_LATQ: begin
                r_q_px <= r_rd_px;
                r_q_py <= r_rd_py;
                r_q_m  <= r_rd_m;
                r_q_fx <= r_rd_fx;
                r_q_fy <= r_rd_fy;
            end
            C_LATK: begin
                r_k_m  <= r_rd_m;
                r_k_fx <= r_rd_fx;
                r_k_fy <= r_rd_fy;
                r_ax   <= adx[31:0];
                r_ay   <= ady[31:0];
                r_sgx  <= dx[32];
                r_sgy  <= dy[32];
                r_s    <= adx[31] | ady[31];
            end
            C_LATU: begin
                r_q_px <= r_rd_px;
                r_q_py <= r_rd_py;
                r_q_vx <= r_rd_vx;
                r_q_vy <= r_rd_vy;
                r_q_m  <= r_rd_m;
                r_q_fx <= r_rd_fx;
                r_q_fy <= r_rd_fy;
            end
            default: ;
        endcase
        if (r_fin) begin
            case (r_eop)
                C_SQX:  r_sq <= r_p[62:0];
                C_SQY:  r_sq <= r_sq + r_p[62:0];
                C_SQRT: r_r  <= r_s ? {r_eb, 1'b0} : {1'b0, r_eb};
                C_MGQ, C_MMK, C_AFX, C_AFY: r_c <= mulq_v;
                C_DIVR: r_c  <= divq_v;
                C_MFX:  r_fx <= mulq_v[46:0];
                C_MFY:  r_fy <= mulq_v[46:0];
                C_MVX:  r_q_px <= sat32(mv_x);
                C_MVY:  r_q_py <= sat32(mv_y);
                C_DVX:  r_q_vx <= sat32(dv_x);
                C_DVY:  r_q_vy <= sat32(dv_y);
                default: ;
            endcase
        end
    end

    // force accumulation: q moves toward k, k gets the opposite
    logic [48:0] fq_x, fq_y, fk_x, fk_y;
    assign fq_x = r_sgx ? ({r_q_fx[47], r_q_fx} + {2'b0, r_fx})
                        : ({r_q_fx[47], r_q_fx} - {2'b0, r_fx});
    assign fq_y = r_sgy ? ({r_q_fy[47], r_q_fy} + {2'b0, r_fy})
                        : ({r_q_fy[47], r_q_fy} - {2'b0, r_fy});
    assign fk_x = r_sgx ? ({r_k_fx[47], r_k_fx} - {2'b0, r_fx})
                        : ({r_k_fx[47], r_k_fx} + {2'b0, r_fx});
    assign fk_y = r_sgy ? ({r_k_fy[47], r_k_fy} - {2'b0, r_fy})
                        : ({r_k_fy[47], r_k_fy} + {2'b0, r_fy});

    // particle state memories
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_LOAD: begin
                mem_m[i_ctl.addr]  <= i_in_data.mass;
                mem_px[i_ctl.addr] <= i_in_data.pos_x;
                mem_py[i_ctl.addr] <= i_in_data.pos_y;
                mem_vx[i_ctl.addr] <= i_in_data.vel_x;
                mem_vy[i_ctl.addr] <= i_in_data.vel_y;
            end
            C_WRU: begin
                mem_px[i_ctl.addr] <= r_q_px;
                mem_py[i_ctl.addr] <= r_q_py;
                mem_vx[i_ctl.addr] <= r_q_vx;
                mem_vy[i_ctl.addr] <= r_q_vy;
            end
            default: ;
        endcase
        r_rd_m  <= mem_m[i_ctl.addr];
        r_rd_px <= mem_px[i_ctl.addr];
        r_rd_py <= mem_py[i_ctl.addr];
        r_rd_vx <= mem_vx[i_ctl.addr];
        r_rd_vy <= mem_vy[i_ctl.addr];
    end

    // force memories
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_CLR: begin
                mem_fx[i_ctl.addr] <= '0;
                mem_fy[i_ctl.addr] <= '0;
            end
            C_WRQ: begin
                mem_fx[i_ctl.addr] <= sat48(fq_x);
                mem_fy[i_ctl.addr] <= sat48(fq_y);
            end
            C_WRK: begin
                mem_fx[i_ctl.addr] <= sat48(fk_x);
                mem_fy[i_ctl.addr] <= sat48(fk_y);
            end
            default: ;
        endcase
        r_rd_fx <= mem_fx[i_ctl.addr];
        r_rd_fy <= mem_fy[i_ctl.addr];
    end

    // result register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.cmd == C_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_EMIT) begin
            r_out <= '{index: i_ctl.addr, out_pos_x: r_rd_px, out_pos_y: r_rd_py,
                       out_vel_x: r_rd_vx, out_vel_y: r_rd_vy, last_out: i_ctl.last};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_sts = '{done: r_fin, r_zero: (r_r == '0), m_zero: (r_q_m == '0),
                     out_full: r_ovalid};

endmodule

`default_nettype wire

[rtl/nbody_gravity_euler_2d.sv]
// ============================================================================
// nbody_gravity_euler_2d
// Direct-sum 2D gravity simulation with explicit Euler steps, Q16.16 fixed point.
// ============================================================================
// Usage:
//  - Input channel: one particle per beat (mass, position, velocity). Beats are
//    taken one per cycle while loading; up to 64 are stored, further ones dropped.
//  - A beat with last set closes the load and starts step_count time steps; the
//    input channel is held off until the last result has been taken.
//  - Each step: clear forces, pass every pair q<k through the shared iterative
//    unit, then update each particle (the velocity step is skipped for zero
//    mass). The single shared multiply/divide/root unit sets the run time.
//  - Output channel: one result per particle in load order, last_out on the
//    final one; a result is read only after the previous one has been taken. A stalled
//    receiver simply holds the result register and pauses the sequencer.
//  - Config channel: always ready; write only while idle. Index 0 time_step,
//    1 grav_const, 2 step_count; other indexes are ignored.
//  - Reset (synchronous, active low) restores register defaults, empties the
//    load and drops any run in progress; memory contents are not cleared.
// ============================================================================
`default_nettype none

module nbody_gravity_euler_2d
    import nbg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [30:0] r_time_step;
    logic [30:0] r_grav_const;
    logic [15:0] r_step_count;
    t_ctl        ctl;
    t_sts        sts;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= 31'd65536;
            r_grav_const <= 31'd65536;
            r_step_count <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP:  r_time_step  <= i_cfg_data[30:0];
                CFG_GRAV_CONST: r_grav_const <= i_cfg_data[30:0];
                CFG_STEP_COUNT: r_step_count <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    nbg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last       (i_in_data.last),
        .o_in_ready   (o_in_ready),
        .i_step_count (r_step_count),
        .i_sts        (sts),
        .o_ctl        (ctl)
    );

    nbg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_in_data    (i_in_data),
        .i_time_step  (r_time_step),
        .i_grav_const (r_grav_const),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

[tb/tb_nbody_gravity_euler_2d.sv]
// ============================================================================
// tb_nbody_gravity_euler_2d
// Self-checking bench for the 2D direct-sum gravity block with Euler steps.
// A table of directed beats and register writes comes first. Loads of random
// particle sets follow, each closed by a beat with last set. A bit-true
// predictor in the bench works out the emitted particles for every set whose
// results the table does not give. A monitor compares each result beat, field
// by field, with the oldest prediction.
// ============================================================================
`default_nettype none

module tb_nbody_gravity_euler_2d;
    import nbg_pkg::*;

    localparam logic [1:0] REG_TIME_STEP  = CFG_TIME_STEP;
    localparam logic [1:0] REG_GRAV_CONST = CFG_GRAV_CONST;
    localparam logic [1:0] REG_STEP_COUNT = CFG_STEP_COUNT;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    localparam int          RANDOM_BEATS = 370;
    localparam int          STALL_LIMIT  = 300000;
    localparam int          LONG_HOLD    = 3000;
    localparam longint      SAT48_HI     = 64'sd140737488355327;
    localparam longint      SAT48_LO     = -64'sd140737488355328;
    localparam longint      SAT32_HI     = 64'sd2147483647;
    localparam longint      SAT32_LO     = -64'sd2147483648;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    nbody_gravity_euler_2d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and particle stores
    // ------------------------------------------------------------------
    longint unsigned dt_q;
    longint unsigned grav_q;
    longint unsigned steps_q;
    longint unsigned body_m  [MAX_PARTICLES];
    longint          body_px [MAX_PARTICLES];
    longint          body_py [MAX_PARTICLES];
    longint          body_vx [MAX_PARTICLES];
    longint          body_vy [MAX_PARTICLES];
    longint          body_fx [MAX_PARTICLES];
    longint          body_fy [MAX_PARTICLES];
    int              bodies_loaded;

    t_out pending_particles[$];
    bit   failed;

    function automatic longint unsigned abs_of(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint clip32(longint v);
        if (v > SAT32_HI) return SAT32_HI;
        if (v < SAT32_LO) return SAT32_LO;
        return v;
    endfunction

    function automatic longint clip48(longint v);
        if (v > SAT48_HI) return SAT48_HI;
        if (v < SAT48_LO) return SAT48_LO;
        return v;
    endfunction

    // Q16.16 magnitude multiply, truncated, clamped at the 48-bit limit
    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] != 0) return SAT48_HI;
        p = p >> 16;
        return (p[63:0] > SAT48_HI) ? SAT48_HI : p[63:0];
    endfunction

    // Q16.16 magnitude divide, truncated, clamped at the 48-bit limit
    function automatic longint unsigned fx_div(longint unsigned a, longint unsigned r);
        longint unsigned quo;
        longint unsigned rem;
        if (r == 0) return SAT48_HI;
        quo = a / r;
        rem = a % r;
        if (quo > (SAT48_HI >> 16)) return SAT48_HI;
        quo = (quo << 16) + ((rem << 16) / r);
        return (quo > SAT48_HI) ? SAT48_HI : quo;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // add the attraction between bodies q and k to both force stores
    task automatic add_pair_pull(int q, int k);
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned rad;
        longint unsigned coef;
        longint          sx;
        longint          sy;
        int              sh;
        dx  = body_px[q] - body_px[k];
        dy  = body_py[q] - body_py[k];
        ax  = abs_of(dx);
        ay  = abs_of(dy);
        sh  = (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) ? 1 : 0;
        rad = floor_sqrt((ax >> sh) * (ax >> sh) + (ay >> sh) * (ay >> sh)) << sh;
        if (rad == 0) return;
        coef = fx_mul(fx_mul(grav_q, body_m[q]), body_m[k]);
        coef = fx_div(fx_div(fx_div(coef, rad), rad), rad);
        sx = longint'(fx_mul(coef, ax));
        sy = longint'(fx_mul(coef, ay));
        if (dx < 0) sx = -sx;
        if (dy < 0) sy = -sy;
        body_fx[q] = clip48(body_fx[q] - sx);
        body_fx[k] = clip48(body_fx[k] + sx);
        body_fy[q] = clip48(body_fy[q] - sy);
        body_fy[k] = clip48(body_fy[k] + sy);
    endtask

    function automatic longint drift(longint p, longint v);
        longint prod;
        longint d;
        prod = longint'(dt_q) * v;
        d    = longint'(abs_of(prod) >> 16);
        return clip32(p + ((prod < 0) ? -d : d));
    endfunction

    function automatic longint kick(longint v, longint f, longint unsigned m);
        longint d;
        if (m == 0) return v;
        d = longint'(fx_div(fx_mul(dt_q, abs_of(f)), m));
        return clip32(v + ((f < 0) ? -d : d));
    endfunction

    // run every time step over the loaded bodies
    task automatic advance_bodies(int n);
        longint unsigned t;
        for (t = 0; t < steps_q; t++) begin
            for (int q = 0; q < n; q++) begin
                body_fx[q] = 0;
                body_fy[q] = 0;
            end
            for (int q = 0; q < n; q++)
                for (int k = q + 1; k < n; k++)
                    add_pair_pull(q, k);
            for (int q = 0; q < n; q++) begin
                body_px[q] = drift(body_px[q], body_vx[q]);
                body_py[q] = drift(body_py[q], body_vy[q]);
                body_vx[q] = kick(body_vx[q], body_fx[q], body_m[q]);
                body_vy[q] = kick(body_vy[q], body_fy[q], body_m[q]);
            end
        end
    endtask

    // store one accepted particle; on last, simulate and queue the emitted set
    task automatic take_particle(t_in b, bit typed, t_out typed_res);
        t_out res;
        if (bodies_loaded < MAX_PARTICLES) begin
            body_m[bodies_loaded]  = b.mass;
            body_px[bodies_loaded] = longint'(b.pos_x);
            body_py[bodies_loaded] = longint'(b.pos_y);
            body_vx[bodies_loaded] = longint'(b.vel_x);
            body_vy[bodies_loaded] = longint'(b.vel_y);
            bodies_loaded++;
        end
        if (!b.last) return;
        advance_bodies(bodies_loaded);
        if (typed) begin
            pending_particles.push_back(typed_res);
        end else begin
            for (int i = 0; i < bodies_loaded; i++) begin
                res.index     = i[5:0];
                res.out_pos_x = body_px[i][31:0];
                res.out_pos_y = body_py[i][31:0];
                res.out_vel_x = body_vx[i][31:0];
                res.out_vel_y = body_vy[i][31:0];
                res.last_out  = (i + 1 == bodies_loaded);
                pending_particles.push_back(res);
            end
        end
        bodies_loaded = 0;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    bit calm_in;
    bit hold_req;

    task automatic send_particle(t_in b, bit typed, t_out typed_res);
        int gap;
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        take_particle(b, typed, typed_res);
    endtask

    // write a register once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TIME_STEP:  dt_q    = val[30:0];
            REG_GRAV_CONST: grav_q  = val[30:0];
            REG_STEP_COUNT: steps_q = val[15:0];
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_particle(bit last, bit wild);
        t_in b;
        if (wild) begin
            b.mass  = 31'($urandom());
            b.pos_x = $urandom();
            b.pos_y = $urandom();
            b.vel_x = $urandom();
            b.vel_y = $urandom();
        end else begin
            b.mass  = 31'($urandom_range(1 << 8, 1 << 20));
            b.pos_x = $urandom_range(0, 1 << 23) - (1 << 22);
            b.pos_y = $urandom_range(0, 1 << 23) - (1 << 22);
            b.vel_x = $urandom_range(0, 1 << 19) - (1 << 18);
            b.vel_y = $urandom_range(0, 1 << 19) - (1 << 18);
        end
        if (b.mass == 0) b.mass = 31'd1;
        b.last = last;
        return b;
    endfunction

    function automatic longint unsigned pick_scale();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 64'd65536;
        if (roll < 9) return $urandom_range(1 << 10, 1 << 18);
        return $urandom_range(1, 32'h7FFF_FFFF);
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_reg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        t_in         beat;
        bit          typed;
        t_out        res;
    } t_row;

    t_row plan[$];

    task automatic row_reg(logic [1:0] idx, logic [31:0] val);
        t_row r;
        r = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        plan.push_back(r);
    endtask

    task automatic row_beat(t_in b);
        t_row r;
        r = '{default: '0};
        r.beat = b;
        plan.push_back(r);
    endtask

    task automatic row_typed(t_in b, t_out res);
        t_row r;
        r = '{default: '0};
        r.beat  = b;
        r.typed = 1'b1;
        r.res   = res;
        plan.push_back(r);
    endtask

    task automatic build_plan();
        // zero steps: loaded values come back unchanged
        row_reg(REG_STEP_COUNT, 32'd0);
        row_typed('{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b1},
                  '{6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b1});
        row_typed('{31'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
                  '{6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
        row_beat('{31'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'd7, 32'hFFFF_FFF9, 1'b0});
        row_beat('{31'h0003_0000, 32'h0000_8000, 32'h0000_4000, 32'd0, 32'd1, 1'b1});
        // one step, lone body: positions saturate, velocity holds
        row_reg(REG_STEP_COUNT, 32'd1);
        row_reg(REG_TIME_STEP, 32'h0001_0000);
        row_typed('{31'h0001_0000, 32'h7FFF_0000, 32'h8001_0000, 32'h0010_0000,
                    32'hFFF0_0000, 1'b1},
                  '{6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
                    32'hFFF0_0000, 1'b1});
        // unit pair, coincident pair, pair too far apart for 32-bit distance
        row_beat('{31'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
        row_beat('{31'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b1});
        row_beat('{31'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd5, 32'd5, 1'b0});
        row_beat('{31'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd5, 32'd5, 1'b1});
        row_beat('{31'h0001_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0});
        row_beat('{31'h0001_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 1'b1});
        // largest constants: force and velocity saturation
        row_reg(REG_GRAV_CONST, 32'h7FFF_FFFF);
        row_reg(REG_TIME_STEP, 32'h7FFF_FFFF);
        row_beat('{31'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
        row_beat('{31'h7FFF_FFFF, 32'd1, 32'd1, 32'd0, 32'd0, 1'b0});
        row_beat('{31'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1});
        // unused index is ignored
        row_reg(REG_UNUSED, 32'hFFFF_FFFF);
        // smallest constants, two steps
        row_reg(REG_TIME_STEP, 32'd1);
        row_reg(REG_GRAV_CONST, 32'd1);
        row_reg(REG_STEP_COUNT, 32'd2);
        row_beat('{31'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 32'h100, 1'b0});
        row_beat('{31'h0000_8000, 32'd0, 32'h0002_0000, 32'h100, 32'd0, 1'b0});
        row_beat('{31'h0004_0000, 32'hFFFE_0000, 32'hFFFE_0000, 32'd0, 32'd0, 1'b1});
        // longest step count written, then replaced before any load
        row_reg(REG_STEP_COUNT, 32'h0000_FFFF);
        row_reg(REG_STEP_COUNT, 32'd3);
        row_reg(REG_TIME_STEP, 32'h0001_0000);
        row_reg(REG_GRAV_CONST, 32'h0001_0000);
        row_beat('{31'h0002_0000, 32'h0001_0000, 32'd0, 32'd0, 32'h0000_8000, 1'b0});
        row_beat('{31'h0002_0000, 32'hFFFF_0000, 32'd0, 32'd0, 32'hFFFF_8000, 1'b1});
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_in  b;
        t_out none;
        int   sent;
        int   n;
        int   sets;
        int   roll;
        none          = '0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_TIME_STEP;
        i_cfg_data    = '0;
        failed        = 1'b0;
        calm_in       = 1'b0;
        hold_req      = 1'b0;
        bodies_loaded = 0;
        dt_q          = 65536;
        grav_q        = 65536;
        steps_q       = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed table
        build_plan();
        foreach (plan[i]) begin
            if (plan[i].is_reg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_particle(plan[i].beat, plan[i].typed, plan[i].res);
        end

        // load overflow: beats past the store are dropped, last still runs
        write_reg(REG_STEP_COUNT, 32'd0);
        calm_in = 1'b1;
        for (int i = 0; i < MAX_PARTICLES + 6; i++) begin
            b = make_particle(i == MAX_PARTICLES + 5, 1'b1);
            send_particle(b, 1'b0, none);
        end
        calm_in = 1'b0;

        // random sets
        sent = 0;
        sets = 0;
        while (sent < RANDOM_BEATS) begin
            if (sets % 8 == 0) begin
                write_reg(REG_TIME_STEP, 32'(pick_scale()));
                write_reg(REG_GRAV_CONST, 32'(pick_scale()));
                roll = $urandom_range(0, 19);
                write_reg(REG_STEP_COUNT, 32'((roll < 14) ? 1 : (roll < 19) ? 2 : 3));
            end
            // arm the long hold-off on a set followed straight away by another
            if (sets == 3) hold_req = 1'b1;
            roll = $urandom_range(0, 19);
            n = (roll < 14) ? $urandom_range(1, 5) :
                (roll < 19) ? $urandom_range(6, 8) : $urandom_range(9, 12);
            calm_in = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) begin
                b = make_particle(i == n - 1, $urandom_range(0, 9) == 0);
                // now and then place a body on top of the previous one
                if (i > 0 && $urandom_range(0, 9) == 0) begin
                    b.pos_x = i_in_data.pos_x;
                    b.pos_y = i_in_data.pos_y;
                end
                send_particle(b, 1'b0, none);
            end
            sent += n;
            sets++;
        end

        // drain
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int  gap;
        bit  held;
        held        = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && hold_req && o_out_valid) begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_particles.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_data);
                failed = 1'b1;
            end else begin
                want = pending_particles.pop_front();
                cmp_field("index", want.index, o_out_data.index);
                cmp_field("out_pos_x", want.out_pos_x, o_out_data.out_pos_x);
                cmp_field("out_pos_y", want.out_pos_y, o_out_data.out_pos_y);
                cmp_field("out_vel_x", want.out_vel_x, o_out_data.out_vel_x);
                cmp_field("out_vel_y", want.out_vel_y, o_out_data.out_vel_y);
                cmp_field("last_out", want.last_out, o_out_data.last_out);
            end
        end
    end

    // watchdog: cycles without any beat on any channel
    int quiet_cycles;
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/nbg_pkg.sv
rtl/nbg_ctrl.sv
rtl/nbg_dp.sv
rtl/nbody_gravity_euler_2d.sv
tb/tb_nbody_gravity_euler_2d.sv
